// ===== src/byte_offset_delta_encoder_defines.svh =====
// Assertion macros used by the checker file of the byte offset delta encoder.
`ifndef BYTE_OFFSET_DELTA_ENCODER_DEFINES_SVH
`define BYTE_OFFSET_DELTA_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge of clk_.
`define BODE_ASSERT_IMPLIES(label, clk_, dis_, ante_, cons_, msg_) \
  label: assert property (@(posedge clk_) disable iff (dis_) (ante_) |-> (cons_)) \
    else $error(msg_);

// Next-cycle implication, sampled on the rising edge of clk_.
`define BODE_ASSERT_NEXT(label, clk_, dis_, ante_, cons_, msg_) \
  label: assert property (@(posedge clk_) disable iff (dis_) (ante_) |=> (cons_)) \
    else $error(msg_);

`endif

// ===== src/bode_pkg.sv =====
// Shared types, constants and byte selection functions of the byte offset delta encoder.
package bode_pkg;

  localparam logic [7:0]  ESC8  = 8'h80;
  localparam logic [15:0] ESC16 = 16'h8000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  // Position of a byte within the code of one pixel (at most seven bytes).
  localparam int IDX_W = 3;

  typedef enum logic [1:0] {
    KIND_SHORT,
    KIND_MID,
    KIND_LONG
  } bode_kind_t;

  typedef struct packed {
    logic [31:0] diff;
    bode_kind_t  kind;
    logic        last;
  } bode_entry_t;

  function automatic logic [IDX_W-1:0] bode_last_idx(input bode_kind_t kind);
    logic [IDX_W-1:0] idx;
    unique case (kind)
      KIND_SHORT: idx = IDX_W'(0);
      KIND_MID:   idx = IDX_W'(2);
      KIND_LONG:  idx = IDX_W'(6);
      default:    idx = IDX_W'(0);
    endcase
    return idx;
  endfunction

  function automatic logic [7:0] bode_byte(input logic [31:0] diff, input bode_kind_t kind,
                                          input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    unique case (kind)
      KIND_SHORT: b = diff[7:0];
      KIND_MID: begin
        case (idx)
          IDX_W'(0): b = ESC8;
          IDX_W'(1): b = diff[7:0];
          default:   b = diff[15:8];
        endcase
      end
      KIND_LONG: begin
        case (idx)
          IDX_W'(0): b = ESC8;
          IDX_W'(1): b = ESC16[7:0];
          IDX_W'(2): b = ESC16[15:8];
          IDX_W'(3): b = diff[7:0];
          IDX_W'(4): b = diff[15:8];
          IDX_W'(5): b = diff[23:16];
          default:   b = diff[31:24];
        endcase
      end
      default: b = diff[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== src/byte_offset_delta_encoder.sv =====
// Top level of the byte offset delta encoder.
// Encodes a stream of signed 32-bit pixels as byte offset deltas: each pixel's difference to the
// previous pixel (modulo 2^32, previous taken as zero at reset and after a pixel flagged
// last_pixel) leaves as 1 byte when it lies in -127..127, as 0x80 plus a 16-bit little-endian
// value when it lies in -32767..32767, and otherwise as 0x80, then 0x00 0x80 (0x8000 sent
// little-endian), then a 32-bit little-endian value (7 bytes); the most negative difference
// takes the long form.
// Both sides behave as queues: a pixel transaction completes when push is high and full low, a
// byte transaction when pop is high and empty low; last_of_pixel marks each pixel's final byte
// and last_of_image the final byte of the image. Pixels are classified on entry and parked in a
// four-entry queue, so up to one pixel per cycle is taken, while the queue is not full, even as
// bytes still wait at the output. The byte serialiser emits one byte per cycle while the output
// register is empty or popped, so an escaped code holds it for its three or seven bytes; a byte
// appears on the outputs at the clock edge after the one that takes its pixel, at the earliest.
module byte_offset_delta_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] pixel_value,
  input  logic               last_pixel,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         code_byte,
  output logic               last_of_pixel,
  output logic               last_of_image
);
  import bode_pkg::*;

  bode_entry_t q_wr_data;
  bode_entry_t q_rd_data;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;

  // Front end: difference and code length, one pixel per cycle while the queue is not full.
  bode_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .pixel_value (pixel_value),
    .last_pixel  (last_pixel),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wr_data)
  );

  // Decoupling queue: absorbs escapes while the front keeps taking pixels.
  bode_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back end: one byte per cycle into the output register while it is empty or popped.
  bode_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_rd_data),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .code_byte     (code_byte),
    .last_of_pixel (last_of_pixel),
    .last_of_image (last_of_image)
  );

endmodule

// ===== src/bode_front.sv =====
// Front end: accepts pixels, forms the wrapped difference and classifies its code length.
module bode_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic signed [31:0]   pixel_value,
  input  logic                 last_pixel,
  input  logic                 q_full,
  output logic                 q_push,
  output bode_pkg::bode_entry_t q_data
);
  import bode_pkg::*;

  logic [31:0] previous_pixel;
  logic [31:0] diff;
  logic        fits8;
  logic        fits16;

  assign full   = q_full;
  assign q_push = push && !q_full;
  assign diff   = pixel_value - previous_pixel;

  // Negative values fit only when not the most negative of their width.
  assign fits8  = (~|diff[31:7]) || ((&diff[31:7]) && (|diff[6:0]));
  assign fits16 = (~|diff[31:15]) || ((&diff[31:15]) && (|diff[14:0]));

  always_comb begin
    q_data.diff = diff;
    q_data.last = last_pixel;
    if (fits8) begin
      q_data.kind = KIND_SHORT;
    end else if (fits16) begin
      q_data.kind = KIND_MID;
    end else begin
      q_data.kind = KIND_LONG;
    end
  end

  // Hold the previous pixel; drop it to zero after the last pixel of an image.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pixel <= '0;
    end else if (q_push) begin
      previous_pixel <= last_pixel ? '0 : pixel_value;
    end
  end

endmodule

// ===== src/bode_queue.sv =====
// Short register queue between the front end and the byte serialiser.
module bode_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  bode_pkg::bode_entry_t wr_data,
  input  logic                  rd_en,
  output bode_pkg::bode_entry_t rd_data,
  output logic                  full,
  output logic                  empty
);
  import bode_pkg::*;

  bode_entry_t         entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_CW-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign full    = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + QUEUE_AW'(1);
      end
      if (do_rd) begin
        rptr <= rptr + QUEUE_AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + QUEUE_CW'(1);
        2'b01:   count <= count - QUEUE_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/bode_back.sv =====
// Back end: walks the queued codes byte by byte into a registered output stage.
module bode_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  bode_pkg::bode_entry_t q_data,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            code_byte,
  output logic                  last_of_pixel,
  output logic                  last_of_image
);
  import bode_pkg::*;

  logic             out_valid;
  logic [IDX_W-1:0] idx;
  logic             load;
  logic             at_end;

  assign empty  = !out_valid;
  assign load   = !q_empty && (!out_valid || pop);
  assign at_end = (idx == bode_last_idx(q_data.kind));
  assign q_pop  = load && at_end;

  always_ff @(posedge clk) begin
    if (load) begin
      code_byte     <= bode_byte(q_data.diff, q_data.kind, idx);
      last_of_pixel <= at_end;
      last_of_image <= at_end && q_data.last;
    end
  end

  // Advance the byte index; retire the head item on its final byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? '0 : idx + IDX_W'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/bode_checker.sv =====
// Port-level checker of the byte offset delta encoder, bound to the top level.
`include "byte_offset_delta_encoder_defines.svh"

module bode_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] code_byte,
  input logic       last_of_pixel,
  input logic       last_of_image
);
  import bode_pkg::*;

  logic first_byte;

  // Track whether the byte on show opens a new pixel code.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_byte <= 1'b1;
    end else if (pop && !empty) begin
      first_byte <= last_of_pixel;
    end
  end

  `BODE_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(code_byte), "byte dropped or changed while stalled")
  `BODE_ASSERT_IMPLIES(a_image_end, clk, rst, !empty && last_of_image, last_of_pixel, "image end not on a pixel end")
  `BODE_ASSERT_IMPLIES(a_escape, clk, rst, !empty && first_byte && !last_of_pixel, code_byte == ESC8, "multi-byte code without escape")
  `BODE_ASSERT_IMPLIES(a_short, clk, rst, !empty && first_byte && last_of_pixel, code_byte != ESC8, "single-byte code equals escape")

endmodule

bind byte_offset_delta_encoder bode_checker u_bode_checker (.*);

// ===== bench/testbench.sv =====
// Testbench for the byte offset delta encoder: a directed table, then a random pixel stream.
module testbench;
  import bode_pkg::*;

  // Code of one pixel: byte count and up to seven bytes, first byte in the top eight bits.
  // A count of zero in a table row means "take the predicted code".
  typedef struct packed {
    logic [2:0]  n;
    logic [55:0] bytes;
  } pixel_code_t;

  typedef struct packed {
    logic [31:0] pix;
    logic        last;
    pixel_code_t code;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] code;
    logic       end_of_pixel;
    logic       end_of_image;
  } out_byte_t;

  localparam pixel_code_t PREDICT = '0;

  // Directed rows, walked in order from reset (previous pixel zero). Hand-typed codes cover
  // the short/escaped boundaries, the most negative difference and the image-end cases.
  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{32'h0000_0005, 1'b0, '{3'd1, 56'h05_00_00_00_00_00_00}},  // small positive
    '{32'h0000_0084, 1'b0, '{3'd1, 56'h7F_00_00_00_00_00_00}},  // +127, widest short
    '{32'h0000_0005, 1'b0, '{3'd1, 56'h81_00_00_00_00_00_00}},  // -127
    '{32'hFFFF_FF85, 1'b0, '{3'd3, 56'h80_80_FF_00_00_00_00}},  // -128 escapes to 16 bits
    '{32'h0000_0005, 1'b0, '{3'd3, 56'h80_80_00_00_00_00_00}},  // +128
    '{32'h0000_8004, 1'b0, '{3'd3, 56'h80_FF_7F_00_00_00_00}},  // +32767
    '{32'h0000_0005, 1'b0, '{3'd3, 56'h80_01_80_00_00_00_00}},  // -32767
    '{32'hFFFF_8005, 1'b0, '{3'd7, 56'h80_00_80_00_80_FF_FF}},  // -32768 escapes to 32 bits
    '{32'h0000_0005, 1'b0, '{3'd7, 56'h80_00_80_00_80_00_00}},  // +32768
    '{32'h7FFF_FFFF, 1'b0, PREDICT},
    '{32'h8000_0000, 1'b0, PREDICT},                             // wraps to +1
    '{32'h8000_0000, 1'b1, '{3'd1, 56'h00_00_00_00_00_00_00}},  // zero delta, image end
    '{32'h8000_0000, 1'b0, '{3'd7, 56'h80_00_80_00_00_00_80}},  // most negative difference
    '{32'h7FFF_FFFF, 1'b1, '{3'd1, 56'hFF_00_00_00_00_00_00}},  // wraps to -1, image end
    '{32'hFFFF_FFFF, 1'b0, '{3'd1, 56'hFF_00_00_00_00_00_00}},
    '{32'h0000_0000, 1'b1, '{3'd1, 56'h01_00_00_00_00_00_00}},
    '{32'h0000_0000, 1'b1, '{3'd1, 56'h00_00_00_00_00_00_00}},  // back-to-back image ends
    '{32'h1234_5678, 1'b1, PREDICT},                             // long code closing an image
    '{32'h0000_012C, 1'b0, '{3'd3, 56'h80_2C_01_00_00_00_00}},
    '{32'hA5A5_5A5A, 1'b0, PREDICT},
    '{32'h5A5A_A5A5, 1'b1, PREDICT},
    '{32'h0000_0100, 1'b0, PREDICT}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [31:0] pixel_value = '0;
  logic        last_pixel = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  code_byte;
  logic        last_of_pixel;
  logic        last_of_image;

  logic [31:0] prior_pixel = '0;     // predictor's copy of the previous pixel
  out_byte_t   expected_bytes[$];    // bytes still owed by the block, oldest first
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_requests = 0;    // bump to ask the byte sink for one long hold-off

  byte_offset_delta_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .pixel_value   (pixel_value),
    .last_pixel    (last_pixel),
    .empty         (empty),
    .pop           (pop),
    .code_byte     (code_byte),
    .last_of_pixel (last_of_pixel),
    .last_of_image (last_of_image)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch at %0t: %s, expected %0h, got %0h", $realtime, what, want, got);
    error_count++;
  endtask

  // Encode one pixel against the previous one and advance the previous pixel.
  function automatic pixel_code_t encode_delta(input logic [31:0] pix, input logic last);
    logic [31:0] delta;
    logic [31:0] mag;
    bode_kind_t  kind;
    pixel_code_t c;
    delta = pix - prior_pixel;
    mag   = delta[31] ? -delta : delta;   // -2^31 stays 0x80000000, so it goes long
    if (mag < 32'h80)
      kind = KIND_SHORT;
    else if (mag < 32'h8000)
      kind = KIND_MID;
    else
      kind = KIND_LONG;
    case (kind)
      KIND_SHORT: c = '{3'd1, {delta[7:0], 48'h0}};
      KIND_MID:   c = '{3'd3, {ESC8, delta[7:0], delta[15:8], 32'h0}};
      default:    c = '{3'd7, {ESC8, ESC16[7:0], ESC16[15:8],
                               delta[7:0], delta[15:8], delta[23:16], delta[31:24]}};
    endcase
    prior_pixel = last ? 32'h0 : pix;
    return c;
  endfunction

  task automatic queue_pixel_bytes(input pixel_code_t c, input logic last);
    out_byte_t b;
    for (int k = 0; k < c.n; k++) begin
      b.code         = c.bytes[55 - 8*k -: 8];
      b.end_of_pixel = (k == c.n - 1);
      b.end_of_image = last && (k == c.n - 1);
      expected_bytes.push_back(b);
    end
  endtask

  // Offer one pixel, idling first at the sender's rate, and hold it until the block takes it.
  // Full is read at the edge itself, so it is the value the block saw with push high.
  task automatic offer_pixel(input logic [31:0] pix, input logic last, input pixel_code_t typed);
    pixel_code_t c;
    while ($urandom_range(99) < send_idle_pct) begin
      push        <= 1'b0;
      pixel_value <= $urandom;              // junk on the bus while idle
      last_pixel  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    push        <= 1'b1;
    pixel_value <= pix;
    last_pixel  <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    c = encode_delta(pix, last);
    queue_pixel_bytes((typed.n != 0) ? typed : c, last);
  endtask

  // Random pixel: mostly a chosen delta from the previous pixel, weighted to short codes,
  // with boundary deltas, escaped deltas and some wholly random pixels mixed in.
  task automatic offer_random_pixel();
    logic [31:0] delta;
    logic [31:0] pix;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 45)
      delta = $urandom_range(254) - 127;
    else if (pick < 57) begin
      case ($urandom_range(4))
        0:       delta = 32'd127;
        1:       delta = 32'd128;
        2:       delta = 32'd32767;
        3:       delta = 32'd32768;
        default: delta = 32'h8000_0000;
      endcase
      if ($urandom_range(1)) delta = -delta;
    end else if (pick < 75)
      delta = $urandom_range(65534) - 32767;
    else
      delta = $urandom;
    pix = (pick >= 90) ? 32'($urandom) : prior_pixel + delta;
    offer_pixel(pix, $urandom_range(9) == 0, PREDICT);
  endtask

  // Byte sink: check each accepted byte against the oldest expectation, then choose pop for
  // the next edge from the stall rate or a pending long hold-off.
  always @(posedge clk) begin : byte_sink
    out_byte_t want;
    int        hold_left;
    int        holds_served;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("byte with nothing expected", '0, 32'(code_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (code_byte !== want.code)
            report_mismatch("code_byte", 32'(want.code), 32'(code_byte));
          if (last_of_pixel !== want.end_of_pixel)
            report_mismatch("last_of_pixel", 32'(want.end_of_pixel), 32'(last_of_pixel));
          if (last_of_image !== want.end_of_image)
            report_mismatch("last_of_image", 32'(want.end_of_image), 32'(last_of_image));
        end
      end
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    int send_rates [4];
    int stall_rates [4];
    send_rates  = '{0, 47, 0, 18};
    stall_rates = '{0, 0, 47, 18};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed table first, with both sides flowing freely.
    for (int r = 0; r < DIR_ROWS; r++)
      offer_pixel(DIRECTED[r].pix, DIRECTED[r].last, DIRECTED[r].code);

    // Hold the byte sink off for a long stretch while pixels keep coming, so the block
    // fills up and raises full.
    hold_requests++;
    repeat (20) offer_random_pixel();

    // Random phases: free flow, sender idling, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_rates[ph];
      recv_stall_pct = stall_rates[ph];
      repeat (32) offer_random_pixel();
    end
    push <= 1'b0;

    // Drain, then wait on for any stray byte to surface.
    recv_stall_pct = 0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("byte_offset_delta_encoder test passed");
    else
      $display("byte_offset_delta_encoder test failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("byte_offset_delta_encoder test failed");
    $finish;
  end

endmodule

// ===== byte_offset_delta_encoder.f =====
+incdir+src
src/bode_pkg.sv
src/bode_front.sv
src/bode_queue.sv
src/bode_back.sv
src/byte_offset_delta_encoder.sv
src/bode_checker.sv
bench/testbench.sv
